### hdl/assert_macros.svh
// assertion macros shared by the line assembler modules
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define TLA_ASSERT(label, clock, reset_n, prop) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) \
        else $error("assertion failed in %m");

// condition must never be seen outside reset
`define TLA_ASSERT_NEVER(label, clock, reset_n, cond) \
    label: assert property (@(posedge clock) disable iff (!reset_n) !(cond)) \
        else $error("forbidden condition seen in %m");

`endif

### hdl/tla_pkg.sv
// shared types and constants of the terminated line assembler
// no dependencies; used by every module of the block
`default_nettype none

package tla_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BUF_AW      = ADDR_W + 1;
    localparam int CNT_W       = 6;
    localparam int LEN_W       = (FILL_W > CNT_W) ? FILL_W : CNT_W;
    localparam int TERM_LEN_W  = 3;
    localparam int TERM_MAX    = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TERM_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 2'd2;

    localparam logic [TERM_LEN_W-1:0] TERM_LEN_RST   = 3'd2;
    localparam logic [31:0]           TERM_BYTES_RST = 32'h0000_0D0A;
    localparam logic [CNT_W-1:0]      OUT_LIMIT_RST  = 6'd63;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_head_t;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

endpackage

`default_nettype wire

### hdl/tla_if.sv
// stream interfaces of the line assembler: received bytes in, line bytes out
// no dependencies
`default_nettype none

interface tla_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tla_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       last_byte;
    logic       empty_line;
    modport source (output valid, output line_byte, output last_byte,
                    output empty_line, input ready);
    modport sink   (input valid, input line_byte, input last_byte,
                    input empty_line, output ready);
endinterface

`default_nettype wire

### hdl/tla_front.sv
// front part: configuration registers, byte transfer, store fill and terminator match
// depends on tla_pkg and tla_if; feeds the line buffer write port and the job queue
`default_nettype none

module tla_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tla_rx_if.sink                              rx_in,
    input  wire logic                           cfg_we,
    input  wire logic [tla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tla_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           q_full,
    output tla_pkg::push_t                      push,
    output tla_pkg::mem_wr_t                    wr
);

    localparam int FILL_W     = tla_pkg::FILL_W;
    localparam int LEN_W      = tla_pkg::LEN_W;
    localparam int CNT_W      = tla_pkg::CNT_W;
    localparam int TERM_LEN_W = tla_pkg::TERM_LEN_W;
    localparam int ADDR_W     = tla_pkg::ADDR_W;

    logic [TERM_LEN_W-1:0] term_len_reg;
    logic [31:0]           term_bytes_reg;
    logic [CNT_W-1:0]      out_limit_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [31:0]           recent_reg;
    logic                  bank_reg;

    logic                  accept;
    logic [TERM_LEN_W-1:0] n_eff;
    logic [FILL_W-1:0]     fill_next;
    logic [31:0]           recent_next;
    logic [3:0]            byte_ok;
    logic                  seen;
    logic                  full_hit;
    logic [FILL_W-1:0]     line_len;
    logic [LEN_W-1:0]      len_ext;
    logic [LEN_W-1:0]      lim_ext;
    logic [CNT_W-1:0]      count;

    assign rx_in.ready = !q_full;
    assign accept      = rx_in.valid && rx_in.ready;

    always_comb
    begin
        n_eff       = (term_len_reg > TERM_LEN_W'(tla_pkg::TERM_MAX))
                      ? TERM_LEN_W'(tla_pkg::TERM_MAX) : term_len_reg;
        fill_next   = fill_reg + FILL_W'(1);
        recent_next = {recent_reg[23:0], rx_in.rx_byte};
        for (int i = 0; i < 4; i++)
        begin
            byte_ok[i] = (TERM_LEN_W'(i) >= n_eff)
                         || (recent_next[8*i +: 8] == term_bytes_reg[8*i +: 8]);
        end
        seen     = (n_eff == '0) || ((fill_next >= FILL_W'(n_eff)) && (&byte_ok));
        full_hit = (fill_next == FILL_W'(tla_pkg::STORE_DEPTH));
        line_len = fill_next - FILL_W'(n_eff);
        len_ext  = LEN_W'(line_len);
        lim_ext  = LEN_W'(out_limit_reg);
        count    = (len_ext < lim_ext) ? CNT_W'(len_ext) : out_limit_reg;
    end

    assign push.push      = accept && seen && !full_hit;
    assign push.job.bank  = bank_reg;
    assign push.job.count = count;

    assign wr.en   = accept;
    assign wr.addr = {bank_reg, fill_reg[ADDR_W-1:0]};
    assign wr.data = rx_in.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_len_reg   <= tla_pkg::TERM_LEN_RST;
            term_bytes_reg <= tla_pkg::TERM_BYTES_RST;
            out_limit_reg  <= tla_pkg::OUT_LIMIT_RST;
            fill_reg       <= '0;
            recent_reg     <= '0;
            bank_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tla_pkg::REG_TERM_LEN:   term_len_reg   <= cfg_data[TERM_LEN_W-1:0];
                    tla_pkg::REG_TERM_BYTES: term_bytes_reg <= cfg_data[31:0];
                    tla_pkg::REG_OUT_LIMIT:  out_limit_reg  <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                if (full_hit || seen)
                begin
                    fill_reg   <= '0;
                    recent_reg <= '0;
                    if (!full_hit)
                    begin
                        bank_reg <= !bank_reg;
                    end
                end
                else
                begin
                    fill_reg   <= fill_next;
                    recent_reg <= recent_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

### hdl/tla_queue.sv
// short queue of finished line jobs between front and back
// depends on tla_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tla_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tla_pkg::push_t push,
    input  wire logic           pop,
    output logic                full,
    output tla_pkg::q_head_t    head
);

    localparam int QPTR_W = tla_pkg::QPTR_W;
    localparam int QCNT_W = tla_pkg::QCNT_W;
    localparam int DEPTH  = tla_pkg::QUEUE_DEPTH;

    tla_pkg::job_t     slot_reg [DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == QCNT_W'(DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            slot_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push.push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push.push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `TLA_ASSERT_NEVER(a_push_full, clk, rst_n, push.push && full)
    `TLA_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !head.valid)
    `TLA_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= QCNT_W'(DEPTH))

endmodule

`default_nettype wire

### hdl/tla_back.sv
// back part: two-bank line buffer and the sequencer that transfers line bytes out
// depends on tla_pkg, tla_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module tla_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tla_pkg::mem_wr_t wr,
    input  wire tla_pkg::q_head_t head,
    output logic                  pop,
    tla_line_if.source            line_out
);

    localparam int BUF_AW = tla_pkg::BUF_AW;
    localparam int ADDR_W = tla_pkg::ADDR_W;
    localparam int CNT_W  = tla_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    logic [7:0]       mem [2**BUF_AW];
    logic [7:0]       rd_data_reg;
    state_t           state_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic             last_reg;
    logic             empty_reg;

    logic              out_accept;
    logic              idx_last;
    logic [BUF_AW-1:0] rd_addr;

    assign out_accept = out_valid_reg && line_out.ready;
    assign pop        = out_accept && last_reg;
    assign idx_last   = ((CNT_W + 1)'(idx_reg) + 1'b1) == {1'b0, head.job.count};
    assign rd_addr    = {head.job.bank, idx_reg[ADDR_W-1:0]};

    assign line_out.valid      = out_valid_reg;
    assign line_out.line_byte  = empty_reg ? 8'd0 : rd_data_reg;
    assign line_out.last_byte  = last_reg;
    assign line_out.empty_line = empty_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        if (head.job.count == '0)
                        begin
                            out_valid_reg <= 1'b1;
                            empty_reg     <= 1'b1;
                            last_reg      <= 1'b1;
                            state_reg     <= S_OUT;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    out_valid_reg <= 1'b1;
                    empty_reg     <= 1'b0;
                    last_reg      <= idx_last;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_accept)
                    begin
                        out_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `TLA_ASSERT(a_out_has_job, clk, rst_n, out_valid_reg |-> head.valid)
    `TLA_ASSERT(a_read_then_out, clk, rst_n, (state_reg == S_READ) |=> out_valid_reg)
    `TLA_ASSERT(a_empty_is_last, clk, rst_n, (out_valid_reg && empty_reg) |-> last_reg)

endmodule

`default_nettype wire

### hdl/terminated_line_assembler_top.sv
// Terminated line assembler. Received bytes are taken one per cycle while the job
// queue has room; a byte that completes the configured terminator turns the line
// held so far (terminator removed, cut to out_limit bytes) into a job for the
// back part, which transfers it out as a run of bytes with last_byte on the final
// one, or as a single empty_line result when nothing is left. A store that fills
// to its depth is dropped without output. The back part reads each line byte from the
// line buffer into the output register and fetches the next byte only after line_out
// has taken it. The two-bank buffer and two-entry job queue let two finished
// lines wait, after which rx_in.ready falls until the back part retires a line.
// No clearing pass is needed after reset. Configuration: cfg_index 0 term_len,
// 1 term_bytes, 2 out_limit; write only while the block is idle.
// depends on tla_pkg, tla_if, tla_front, tla_queue and tla_back
`default_nettype none

module terminated_line_assembler_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tla_rx_if.sink                              rx_in,
    tla_line_if.source                          line_out,
    input  wire logic                           cfg_we,
    input  wire logic [tla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tla_pkg::CFG_DATA_W-1:0] cfg_data
);

    tla_pkg::push_t   push;
    tla_pkg::mem_wr_t wr;
    tla_pkg::q_head_t head;
    logic             q_full;
    logic             pop;

    tla_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_in     (rx_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .wr        (wr)
    );

    tla_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    tla_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .head     (head),
        .pop      (pop),
        .line_out (line_out)
    );

endmodule

`default_nettype wire
